>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Shared constants and codes for the heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int KEY_W        = 32;
   localparam int COUNT_W      = 9;

   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

endpackage

>>> hw/rtl/binary_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Array-backed min-heap of signed keys with insert and extract-minimum.
// ----------------------------------------------------------------------------
// Each request is one operation: insert a key or extract the minimum. The heap
// lives in a single-port-write, single-port-read RAM with registered read
// data, and one shared signed comparator is stepped by a small sequencer.
// An insert reads the parent and compares at each level it climbs; an
// extract loads the last entry, then at each level it sinks reads the left
// child, then the right child, then compares, as the one RAM read port
// fetches each child in turn. A refused insert (full) or an empty extract
// goes straight to the result and leaves the heap as it was. The request
// side is ready only while no operation is in progress; one finished result
// may wait in the output register while the next request is taken. No
// clearing pass runs after reset: only entries below the entry count are
// ever used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_min_heap_queue_top #(
   parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [31:0] popped_key, [63:32] current_min,
                                    // [72:64] entry_count, [79:73] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import bmhq_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CHW   = IDX_W + 2;   // child index, may run past the count

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DN_FETCH,
      S_DN_LOAD,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // Heap RAM: one write and one registered read per cycle
   // ------------------------------------------------------------------------
   logic signed [KEY_W-1:0] heap_mem [CAPACITY];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [KEY_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   // ------------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------------
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;         // current hole position
   logic signed [KEY_W-1:0] key_ff, key_in;         // key being moved
   logic signed [KEY_W-1:0] best_ff, best_in;       // smaller of left child and key
   logic                    best_left_ff, best_left_in;
   logic signed [KEY_W-1:0] root_ff, root_in;       // copy of entry 0
   logic signed [KEY_W-1:0] popped_ff, popped_in;
   status_type              stat_ff, stat_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic signed [KEY_W-1:0] rsp_min_ff, rsp_min_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   status_type              rsp_status_ff, rsp_status_in;

   // shared signed comparator
   logic signed [KEY_W-1:0] cmp_a;
   logic signed [KEY_W-1:0] cmp_b;
   logic                    cmp_lt;

   assign cmp_lt = cmp_a < cmp_b;

   // index arithmetic
   logic [CHW-1:0]           lc_w;
   logic [CHW-1:0]           rc_w;
   logic [CHW-1:0]           cnt_w;
   logic [IDX_W-1:0]         parent;
   logic [IDX_W-1:0]         pos_m1;
   logic [CNT_W+COUNT_W-1:0] count_ext;
   logic                     full;

   assign lc_w      = ({2'b00, pos_ff} << 1) + CHW'(1);
   assign rc_w      = lc_w + CHW'(1);
   assign cnt_w     = CHW'(count_ff);
   assign pos_m1    = pos_ff - IDX_W'(1);
   assign parent    = pos_m1 >> 1;
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      best_in       = best_ff;
      best_left_in  = best_left_ff;
      popped_in     = popped_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = key_ff;
      rd_addr       = IDX_W'(count_ff);
      cmp_a         = rd_data_ff;
      cmp_b         = key_ff;

      // drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               popped_in = KEY_MAX;
               stat_in   = STAT_OK;
               if (req_tuser[0] == OP_INSERT) begin
                  if (full) begin
                     stat_in  = STAT_FULL;
                     state_in = S_DONE;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = IDX_W'(count_ff);
                     key_in   = $signed(req_tdata);
                     state_in = S_UP_CHECK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     stat_in  = STAT_EMPTY;
                     state_in = S_DONE;
                  end else begin
                     // the hole starts at the root
                     popped_in = root_ff;
                     pos_in    = '0;
                     count_in  = count_ff - CNT_W'(1);
                     state_in  = (count_ff == CNT_W'(1)) ? S_DONE : S_DN_FETCH;
                  end
               end
            end
         end
         S_UP_CHECK: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = parent;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // move the parent down while the new key is strictly smaller
            cmp_a = key_ff;
            cmp_b = rd_data_ff;
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_data_ff;
               pos_in   = parent;
               state_in = S_UP_CHECK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_FETCH: begin
            rd_addr  = IDX_W'(count_ff);
            state_in = S_DN_LOAD;
         end
         S_DN_LOAD: begin
            key_in   = rd_data_ff;
            state_in = S_DN_LEFT;
         end
         S_DN_LEFT: begin
            if (lc_w >= cnt_w) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = IDX_W'(lc_w);
               state_in = S_DN_RIGHT;
            end
         end
         S_DN_RIGHT: begin
            rd_addr      = IDX_W'(rc_w);
            cmp_a        = rd_data_ff;
            cmp_b        = key_ff;
            best_left_in = cmp_lt;
            best_in      = cmp_lt ? rd_data_ff : key_ff;
            state_in     = S_DN_CMP;
         end
         S_DN_CMP: begin
            // right child wins only when strictly smaller than the best so far
            cmp_a = rd_data_ff;
            cmp_b = best_ff;
            wr_en = 1'b1;
            if ((rc_w < cnt_w) && cmp_lt) begin
               wr_data  = rd_data_ff;
               pos_in   = IDX_W'(rc_w);
               state_in = S_DN_LEFT;
            end else if (best_left_ff) begin
               wr_data  = best_ff;
               pos_in   = IDX_W'(lc_w);
               state_in = S_DN_LEFT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = popped_ff;
               rsp_status_in = stat_ff;
               rsp_min_in    = (count_ff != '0) ? root_ff : KEY_MAX;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // keep the root copy in step with writes to entry 0
      root_in = root_ff;
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      best_ff       <= best_in;
      best_left_ff  <= best_left_in;
      root_ff       <= root_in;
      popped_ff     <= popped_in;
      stat_ff       <= stat_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_min_ff, rsp_popped_ff};
   assign rsp_tuser  = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLY(a_empty_result, clock, reset,
                 rsp_valid_ff && (rsp_status_ff == STAT_EMPTY),
                 (rsp_popped_ff == KEY_MAX) && (rsp_min_ff == KEY_MAX)
                    && (rsp_count_ff == '0))

endmodule
